@@ rtl/core/u8lim_pkg.sv @@
// Shared types and constants for the UTF-8 encoder with byte limit.
package u8lim_pkg;

    localparam int CP_W        = 31;
    localparam int CNT_W       = 16;
    localparam int BYTES_W     = 17;
    localparam int CFG_INDEX_W = 4;
    localparam int NUM_W       = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_ENABLE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTE_LIMIT   = 4'd1;

    localparam logic [CP_W-1:0] CP_MAX_1B = 31'h0000007F;
    localparam logic [CP_W-1:0] CP_MAX_2B = 31'h000007FF;
    localparam logic [CP_W-1:0] CP_MAX_3B = 31'h0000FFFF;
    localparam logic [CP_W-1:0] CP_MAX_4B = 31'h0010FFFF;

    localparam logic [7:0] LEAD_2B   = 8'hC0;
    localparam logic [7:0] LEAD_3B   = 8'hE0;
    localparam logic [7:0] LEAD_4B   = 8'hF0;
    localparam logic [7:0] CONT_MARK = 8'h80;

    localparam logic [CNT_W-1:0]   COUNT_MAX = 16'hFFFF;
    localparam logic [BYTES_W-1:0] BYTES_MAX = 17'h1FFFF;

    // Per-string running state.
    typedef struct packed {
        logic [BYTES_W-1:0] bytes_emitted;
        logic [CNT_W-1:0]   chars_seen;
        logic               cut_off;
    } u8lim_state_t;

    // Everything one code point produces; bytes[0] goes out first.
    typedef struct packed {
        logic [3:0][7:0]  bytes;
        logic [NUM_W-1:0] count;
        logic             has_byte;
        logic             string_end;
        logic [CNT_W-1:0] char_count;
        logic [CNT_W-1:0] byte_count;
    } u8lim_batch_t;

endpackage

@@ rtl/core/u8lim_encode.sv @@
// Code point to UTF-8 byte group, with byte limit check and counter update.
module u8lim_encode
    import u8lim_pkg::*;
(
    input  logic [CP_W-1:0]  code_point,
    input  logic             string_last,
    input  logic             limit_enable,
    input  logic [CNT_W-1:0] byte_limit,
    input  u8lim_state_t     state,
    output u8lim_state_t     state_next,
    output u8lim_batch_t     batch
);

    logic [3:0][7:0]    enc_bytes;
    logic [NUM_W-1:0]   enc_num;
    logic [NUM_W-1:0]   num;
    logic [BYTES_W:0]   total;
    logic               over;
    logic [BYTES_W:0]   sum;
    logic [BYTES_W-1:0] bytes_new;
    logic [CNT_W-1:0]   chars_new;
    logic               cut_new;

    always_comb
    begin
        enc_bytes = '0;
        priority if (code_point <= CP_MAX_1B)
        begin
            enc_num      = 3'd1;
            enc_bytes[0] = {1'b0, code_point[6:0]};
        end
        else if (code_point <= CP_MAX_2B)
        begin
            enc_num      = 3'd2;
            enc_bytes[0] = LEAD_2B | {3'b000, code_point[10:6]};
            enc_bytes[1] = CONT_MARK | {2'b00, code_point[5:0]};
        end
        else if (code_point <= CP_MAX_3B)
        begin
            enc_num      = 3'd3;
            enc_bytes[0] = LEAD_3B | {4'b0000, code_point[15:12]};
            enc_bytes[1] = CONT_MARK | {2'b00, code_point[11:6]};
            enc_bytes[2] = CONT_MARK | {2'b00, code_point[5:0]};
        end
        else if (code_point <= CP_MAX_4B)
        begin
            enc_num      = 3'd4;
            enc_bytes[0] = LEAD_4B | {5'b00000, code_point[20:18]};
            enc_bytes[1] = CONT_MARK | {2'b00, code_point[17:12]};
            enc_bytes[2] = CONT_MARK | {2'b00, code_point[11:6]};
            enc_bytes[3] = CONT_MARK | {2'b00, code_point[5:0]};
        end
        else
        begin
            enc_num = 3'd0;
        end
    end

    always_comb
    begin
        // Check the whole character against the limit; drop it and the rest if it overflows.
        total   = {1'b0, state.bytes_emitted} + {{(BYTES_W+1-NUM_W){1'b0}}, enc_num};
        over    = !state.cut_off && limit_enable
                  && (total > {{(BYTES_W+1-CNT_W){1'b0}}, byte_limit});
        num     = (state.cut_off || over) ? 3'd0 : enc_num;
        cut_new = state.cut_off || over;

        sum       = {1'b0, state.bytes_emitted} + {{(BYTES_W+1-NUM_W){1'b0}}, num};
        bytes_new = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
        chars_new = (state.chars_seen == COUNT_MAX) ? COUNT_MAX
                                                    : state.chars_seen + 16'd1;

        batch.bytes      = (num == 3'd0) ? '0 : enc_bytes;
        batch.count      = (num == 3'd0) ? 3'd1 : num;
        batch.has_byte   = (num != 3'd0);
        batch.string_end = string_last;
        batch.char_count = chars_new;
        batch.byte_count = bytes_new[BYTES_W-1] ? COUNT_MAX : bytes_new[CNT_W-1:0];

        if (string_last)
        begin
            state_next = '0;
        end
        else
        begin
            state_next.bytes_emitted = bytes_new;
            state_next.chars_seen    = chars_new;
            state_next.cut_off       = cut_new;
        end
    end

endmodule

@@ rtl/core/u8lim_emit.sv @@
// Result register that sends a byte group out one beat at a time.
module u8lim_emit
    import u8lim_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_valid,
    output logic             load_ready,
    input  u8lim_batch_t     batch,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       data_byte,
    output logic             has_byte,
    output logic             run_last,
    output logic             string_end,
    output logic [CNT_W-1:0] char_count,
    output logic [CNT_W-1:0] byte_count
);

    logic             busy_reg, busy_next;
    logic [NUM_W-1:0] left_reg, left_next;
    logic [3:0][7:0]  bytes_reg, bytes_next;
    logic             has_reg;
    logic             end_reg;
    logic [CNT_W-1:0] chars_reg;
    logic [CNT_W-1:0] total_reg;
    logic             out_fire;
    logic             load_fire;

    assign out_fire   = busy_reg && out_ready;
    assign load_ready = !busy_reg || (out_ready && left_reg == 3'd1);
    assign load_fire  = load_valid && load_ready;

    always_comb
    begin
        busy_next  = busy_reg;
        left_next  = left_reg;
        bytes_next = bytes_reg;
        if (load_fire)
        begin
            busy_next  = 1'b1;
            left_next  = batch.count;
            bytes_next = batch.bytes;
        end
        else if (out_fire)
        begin
            // Advance to the next byte of the group, or go empty after the last.
            busy_next  = (left_reg != 3'd1);
            left_next  = left_reg - 3'd1;
            bytes_next = bytes_reg >> 8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            left_reg <= 3'd1;
        end
        else
        begin
            busy_reg <= busy_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        if (load_fire)
        begin
            has_reg   <= batch.has_byte;
            end_reg   <= batch.string_end;
            chars_reg <= batch.char_count;
            total_reg <= batch.byte_count;
        end
    end

    assign out_valid  = busy_reg;
    assign data_byte  = bytes_reg[0];
    assign has_byte   = has_reg;
    assign run_last   = (left_reg == 3'd1);
    assign string_end = end_reg && (left_reg == 3'd1);
    assign char_count = chars_reg;
    assign byte_count = total_reg;

endmodule

@@ rtl/core/utf8_encode_with_byte_limit.sv @@
// UTF-8 encoder with per-string byte limit: top level.
// Each accepted code point yields 1 to 4 output beats, one per encoded
// byte, or a single empty-marker beat when it produces no bytes (value
// above 0x10FFFF, over the byte limit, or after the string was cut off).
// The input register accepts a new item every cycle while the output
// stage can take it; sustained rate is one output beat per cycle while
// out_ready is high, and the next item loads as the last beat of the
// current one is taken. The first beat passes the input register, then
// the output register. Counters clear after the item marked string_last.
// Registers (index 0: limit_enable, index 1: byte_limit) are written
// through cfg_* at any time, always ready; other indexes are ignored.
module utf8_encode_with_byte_limit
    import u8lim_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CP_W-1:0]        code_point,
    input  logic                   string_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             data_byte,
    output logic                   has_byte,
    output logic                   run_last,
    output logic                   string_end,
    output logic [CNT_W-1:0]       char_count,
    output logic [CNT_W-1:0]       byte_count
);

    logic             limit_enable_reg;
    logic [CNT_W-1:0] byte_limit_reg;
    logic             in_valid_reg, in_valid_next;
    logic [CP_W-1:0]  cp_reg;
    logic             last_reg;
    u8lim_state_t     state_reg;
    u8lim_state_t     state_next;
    u8lim_batch_t     batch;
    logic             load_ready;
    logic             load_fire;
    logic             in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = !in_valid_reg || load_ready;
    assign in_fire   = in_valid && in_ready;
    assign load_fire = in_valid_reg && load_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (load_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_enable_reg <= 1'b0;
            byte_limit_reg   <= '0;
            in_valid_reg     <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_LIMIT_ENABLE: limit_enable_reg <= cfg_data[0];
                    CFG_BYTE_LIMIT:   byte_limit_reg   <= cfg_data;
                    default:          ;
                endcase
            end
            in_valid_reg <= in_valid_next;
            if (load_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Hold the input beat until the encoder hands it to the output stage.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cp_reg   <= code_point;
            last_reg <= string_last;
        end
    end

    u8lim_encode u_encode (
        .code_point   (cp_reg),
        .string_last  (last_reg),
        .limit_enable (limit_enable_reg),
        .byte_limit   (byte_limit_reg),
        .state        (state_reg),
        .state_next   (state_next),
        .batch        (batch)
    );

    u8lim_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid_reg),
        .load_ready (load_ready),
        .batch      (batch),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .run_last   (run_last),
        .string_end (string_end),
        .char_count (char_count),
        .byte_count (byte_count)
    );

`ifndef SYNTHESIS
    // An empty marker is always a single-beat run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> run_last)
        else $error("empty marker not marked as run end");

    // A taken beat that is not the run end leaves more bytes to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid && has_byte)
        else $error("byte group cut short");

    // Within a run, the counts stay fixed from beat to beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=>
            char_count == $past(char_count) && byte_count == $past(byte_count))
        else $error("counts changed inside a byte group");

    // The end of a string is flagged only on the last beat of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("string end off the run end");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the UTF-8 encoder with per-string byte limit.
`timescale 1ns / 100ps

module tb
    import u8lim_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int          RX_HOLD_CYCLES  = 200;
    localparam int          TAIL_CYCLES     = 16;
    localparam int          MAX_PRINTED     = 50;

    // Index past the register list; the block must ignore it.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 4'hF;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            fin;
    } char_item_t;

    typedef struct packed {
        logic [7:0]       data;
        logic             has_data;
        logic             run_end;
        logic             str_end;
        logic [CNT_W-1:0] chars;
        logic [CNT_W-1:0] bytes;
    } utf8_beat_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CNT_W-1:0]       cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    logic [CP_W-1:0]        code_point  = '0;
    logic                   string_last = 1'b0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic [7:0]             data_byte;
    logic                   has_byte;
    logic                   run_last;
    logic                   string_end;
    logic [CNT_W-1:0]       char_count;
    logic [CNT_W-1:0]       byte_count;

    // Encoder state and register copies
    logic                   limit_on        = 1'b0;
    logic [CNT_W-1:0]       limit_bytes     = '0;
    logic [BYTES_W-1:0]     bytes_in_string = '0;
    logic [CNT_W-1:0]       chars_in_string = '0;
    logic                   string_cut      = 1'b0;

    char_item_t chars_to_send[$];
    utf8_beat_t utf8_beats_due[$];
    int         chars_unaccepted = 0;

    logic steady      = 1'b0;
    logic rx_hold_req = 1'b0;
    logic rx_hold     = 1'b0;

    int          mismatches       = 0;
    int          chars_encoded    = 0;
    int          strings_closed   = 0;
    int          cut_strings      = 0;
    int          beats_checked    = 0;
    int          settings_written = 0;
    int unsigned cycle_count      = 0;

    utf8_encode_with_byte_limit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .code_point  (code_point),
        .string_last (string_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_byte   (data_byte),
        .has_byte    (has_byte),
        .run_last    (run_last),
        .string_end  (string_end),
        .char_count  (char_count),
        .byte_count  (byte_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("utf8_encode_with_byte_limit regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] want,
                                   input logic [CNT_W-1:0] got);
        if (mismatches < MAX_PRINTED)
            $display("beat %0d: %s expected 0x%0h, got 0x%0h", beats_checked, what, want, got);
        mismatches++;
    endtask

    // Encode one code point against the running string state; queue its beats.
    task automatic encode_char(input logic [CP_W-1:0] cp, input logic fin);
        logic [7:0]       enc [4];
        int               n;
        int               sum;
        int               k;
        logic [CNT_W-1:0] shown;
        utf8_beat_t       b;
        n = 0;
        if (chars_in_string != COUNT_MAX)
            chars_in_string++;
        if (!string_cut)
        begin
            if (cp <= CP_MAX_1B)
            begin
                enc[0] = cp[7:0];
                n = 1;
            end
            else if (cp <= CP_MAX_2B)
            begin
                enc[0] = LEAD_2B | {3'b0, cp[10:6]};
                enc[1] = CONT_MARK | {2'b0, cp[5:0]};
                n = 2;
            end
            else if (cp <= CP_MAX_3B)
            begin
                enc[0] = LEAD_3B | {4'b0, cp[15:12]};
                enc[1] = CONT_MARK | {2'b0, cp[11:6]};
                enc[2] = CONT_MARK | {2'b0, cp[5:0]};
                n = 3;
            end
            else if (cp <= CP_MAX_4B)
            begin
                enc[0] = LEAD_4B | {5'b0, cp[20:18]};
                enc[1] = CONT_MARK | {2'b0, cp[17:12]};
                enc[2] = CONT_MARK | {2'b0, cp[11:6]};
                enc[3] = CONT_MARK | {2'b0, cp[5:0]};
                n = 4;
            end
            // Drop the whole character once it would overrun the limit.
            if (limit_on && int'(bytes_in_string) + n > int'(limit_bytes))
            begin
                string_cut = 1'b1;
                n = 0;
                cut_strings++;
            end
        end
        sum = int'(bytes_in_string) + n;
        bytes_in_string = (sum > int'(BYTES_MAX)) ? BYTES_MAX : BYTES_W'(sum);
        shown = (bytes_in_string > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                      : bytes_in_string[CNT_W-1:0];
        if (n == 0)
        begin
            b = '{8'h00, 1'b0, 1'b1, fin, chars_in_string, shown};
            utf8_beats_due.push_back(b);
        end
        else
        begin
            for (k = 0; k < n; k++)
            begin
                b = '{enc[k], 1'b1, k == n - 1, (k == n - 1) && fin, chars_in_string, shown};
                utf8_beats_due.push_back(b);
            end
        end
        if (fin)
        begin
            bytes_in_string = '0;
            chars_in_string = '0;
            string_cut      = 1'b0;
            strings_closed++;
        end
    endtask

    // Input side: offer queued code points, predict on each accepted beat.
    always @(posedge clk)
    begin : drive_chars
        char_item_t nxt;
        logic       offer;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                encode_char(code_point, string_last);
                chars_encoded++;
                chars_unaccepted--;
            end
            if (!in_valid || in_ready)
            begin
                offer = chars_to_send.size() != 0 && (steady || $urandom_range(99) >= 29);
                if (offer)
                begin
                    nxt = chars_to_send.pop_front();
                    code_point  <= nxt.cp;
                    string_last <= nxt.fin;
                end
                in_valid <= offer;
            end
        end
    end

    // Output side: check each accepted beat against the oldest prediction.
    always @(posedge clk)
    begin : check_bytes
        utf8_beat_t due;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                beats_checked++;
                if (utf8_beats_due.size() == 0)
                    report_mismatch("beat with nothing pending, data_byte", '0, data_byte);
                else
                begin
                    due = utf8_beats_due.pop_front();
                    if (data_byte !== due.data)
                        report_mismatch("data_byte", due.data, data_byte);
                    if (has_byte !== due.has_data)
                        report_mismatch("has_byte", due.has_data, has_byte);
                    if (run_last !== due.run_end)
                        report_mismatch("run_last", due.run_end, run_last);
                    if (string_end !== due.str_end)
                        report_mismatch("string_end", due.str_end, string_end);
                    if (char_count !== due.chars)
                        report_mismatch("char_count", due.chars, char_count);
                    if (byte_count !== due.bytes)
                        report_mismatch("byte_count", due.bytes, byte_count);
                end
            end
            out_ready <= !rx_hold && (steady || $urandom_range(99) >= 29);
        end
    end

    // Long receiver hold-off, counted here while the sender keeps offering.
    always
    begin
        wait (rx_hold_req);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
        wait (!rx_hold_req);
    end

    task automatic queue_char(input logic [CP_W-1:0] cp, input logic fin);
        char_item_t it;
        it = '{cp, fin};
        chars_to_send.push_back(it);
        chars_unaccepted++;
    endtask

    function automatic logic [CP_W-1:0] pick_code_point();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2: return CP_W'($urandom_range(32'h7F));
            3, 4:    return CP_W'($urandom_range(32'h7FF, 32'h80));
            5, 6:    return CP_W'($urandom_range(32'hFFFF, 32'h800));
            7, 8:    return CP_W'($urandom_range(32'h10FFFF, 32'h10000));
            default: return CP_W'($urandom_range(32'h7FFFFFFF, 32'h110000));
        endcase
    endfunction

    task automatic queue_strings(input int n_chars, input int max_len);
        int left;
        int len;
        int k;
        left = n_chars;
        while (left > 0)
        begin
            len = $urandom_range(max_len, 1);
            if (len > left)
                len = left;
            for (k = 0; k < len; k++)
                queue_char(pick_code_point(), k == len - 1);
            left -= len;
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CNT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LIMIT_ENABLE: limit_on = val[0];
            CFG_BYTE_LIMIT:   limit_bytes = val;
            default: ;
        endcase
        settings_written++;
    endtask

    // Hold until every queued code point is taken and every beat has come back.
    task automatic drain();
        do @(posedge clk); while (chars_unaccepted != 0 || utf8_beats_due.size() != 0);
    endtask

    initial
    begin : stimulus
        int i;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Encoding at reset settings: every length boundary, surrogates, out of range
        queue_char(31'h0, 1'b0);
        queue_char(31'h7F, 1'b0);
        queue_char(31'h80, 1'b0);
        queue_char(31'h7FF, 1'b0);
        queue_char(31'h800, 1'b0);
        queue_char(31'hD800, 1'b0);
        queue_char(31'hDFFF, 1'b0);
        queue_char(31'hFFFF, 1'b0);
        queue_char(31'h10000, 1'b0);
        queue_char(31'h10FFFF, 1'b0);
        queue_char(31'h110000, 1'b0);
        queue_char(31'h7FFFFFFF, 1'b1);
        queue_char(31'h41, 1'b1);
        drain();

        // Cut-off sticks for the rest of the string; an exact fill is kept
        write_reg(CFG_LIMIT_ENABLE, 16'h0001);
        write_reg(CFG_BYTE_LIMIT, 16'd5);
        queue_char(31'h10000, 1'b0);
        queue_char(31'h800, 1'b0);
        queue_char(31'h41, 1'b1);
        queue_char(31'h41, 1'b0);
        queue_char(31'h10FFFF, 1'b1);
        queue_char(31'h7FF, 1'b1);
        drain();

        write_reg(CFG_BYTE_LIMIT, 16'd0);
        queue_char(31'h0, 1'b0);
        queue_char(31'h41, 1'b1);
        drain();

        // Only bit 0 of the enable counts; stray index must not disturb anything
        write_reg(CFG_LIMIT_ENABLE, 16'hFFFE);
        write_reg(CFG_UNUSED, 16'hFFFF);
        queue_char(31'h10000, 1'b0);
        queue_char(31'h10000, 1'b0);
        drain();
        // Turn the limit on in the middle of an open string
        write_reg(CFG_BYTE_LIMIT, 16'd9);
        write_reg(CFG_LIMIT_ENABLE, 16'h0001);
        queue_char(31'h41, 1'b0);
        queue_char(31'h41, 1'b1);
        drain();

        write_reg(CFG_BYTE_LIMIT, 16'hFFFF);
        queue_strings(60, 8);
        drain();

        for (i = 0; i < 4; i++)
        begin
            write_reg(CFG_BYTE_LIMIT, CNT_W'($urandom_range(12)));
            steady = (i == 1);
            queue_strings(55, 6);
            drain();
        end
        steady = 1'b0;

        write_reg(CFG_LIMIT_ENABLE, 16'h0000);
        queue_strings(60, 8);
        drain();

        // Stall the output long enough to back the block up into its input
        write_reg(CFG_LIMIT_ENABLE, 16'h0001);
        write_reg(CFG_BYTE_LIMIT, 16'd20);
        rx_hold_req = 1'b1;
        queue_strings(60, 6);
        drain();
        rx_hold_req = 1'b0;

        write_reg(CFG_LIMIT_ENABLE, 16'h0001);
        write_reg(CFG_BYTE_LIMIT, CNT_W'($urandom_range(16, 4)));
        queue_strings(40, 5);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Encoded %0d code points in %0d strings, %0d output beats checked, %0d cut-offs.",
                 chars_encoded, strings_closed, beats_checked, cut_strings);
        $display("%0d register writes: limit off and on, limits 0 to 65535, mid-string enable.",
                 settings_written);
        if (mismatches == 0)
            $display("utf8_encode_with_byte_limit regression: pass");
        else
            $display("utf8_encode_with_byte_limit regression: fail");
        $finish;
    end

endmodule
